@@ sv/rrc_pkg.sv @@
// Shared types, constants and helpers for the rectangle run coalescer.
package rrc_pkg;

	localparam int BATCH_DEPTH_DEF = 16;
	localparam int SIZE_MAX_OUT    = 4096;
	localparam int SCALE_MAX       = 8;
	localparam int RUN_MAX         = 512;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam logic CFG_SCALE_X = 1'b0;
	localparam logic CFG_SCALE_Y = 1'b1;

	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic [12:0] w;
		logic [12:0] h;
	} rect_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_EMIT,
		ST_APPEND
	} state_t;

	function automatic logic [3:0] scale_sat(input logic [3:0] v);
		logic [3:0] r;
		if (v == 4'd0) begin
			r = 4'd1;
		end else if (v > 4'(SCALE_MAX)) begin
			r = 4'(SCALE_MAX);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [9:0] run_sat(input logic [9:0] v);
		logic [9:0] r;
		if (v == 10'd0) begin
			r = 10'd1;
		end else if (v > 10'(RUN_MAX)) begin
			r = 10'(RUN_MAX);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

@@ sv/rrc_store.sv @@
// Held rectangle memory: one write port, one registered read port.
module rrc_store #(
	parameter int DEPTH = rrc_pkg::BATCH_DEPTH_DEF
) (
	input  logic                     clk,
	input  rrc_pkg::mem_ctl_t        mem_ctl,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  rrc_pkg::rect_t           wr_data,
	output rrc_pkg::rect_t           rd_data
);

	rrc_pkg::rect_t mem [DEPTH];
	rrc_pkg::rect_t rd_data_q;

	always_ff @(posedge clk) begin
		if (mem_ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (mem_ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ sv/rrc_ctrl.sv @@
// Sequencer: merge search, append, batch emit and output register.
module rrc_ctrl #(
	parameter int DEPTH = rrc_pkg::BATCH_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     in_flush,
	input  rrc_pkg::rect_t           in_item,
	output logic                     out_valid,
	input  logic                     out_stall,
	output rrc_pkg::rect_t           out_rect,
	output logic                     out_last,
	output rrc_pkg::mem_ctl_t        mem_ctl,
	output logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [$clog2(DEPTH)-1:0] wr_addr,
	output rrc_pkg::rect_t           wr_data,
	input  rrc_pkg::rect_t           rd_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	rrc_pkg::state_t state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic [AW-1:0]   ptr_q, ptr_d;
	logic            issued_q, issued_d;
	logic            flush_q, flush_d;
	rrc_pkg::rect_t  item_q, item_d;
	logic            pend_s1, pend_d;
	logic [AW-1:0]   addr_s1, addr_d;
	logic            first_s1, first_d;
	logic            out_valid_q, out_valid_d;
	rrc_pkg::rect_t  out_rect_q, out_rect_d;
	logic            out_last_q, out_last_d;

	logic            accept;
	logic [CW-1:0]   cnt_dec;
	logic [AW-1:0]   newest;
	logic            full;
	logic            empty;
	logic [13:0]     x_end, y_end, grown_w, grown_h;
	logic            horiz, vert, merge, miss;
	logic            out_free, emit_last;

	assign in_stall  = (state_q != rrc_pkg::ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign cnt_dec   = count_q - CW'(1);
	assign newest    = cnt_dec[AW-1:0];
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);

	assign x_end   = {2'b00, rd_data.x} + {1'b0, rd_data.w};
	assign y_end   = {2'b00, rd_data.y} + {1'b0, rd_data.h};
	assign grown_w = {1'b0, rd_data.w} + {1'b0, item_q.w};
	assign grown_h = {1'b0, rd_data.h} + {1'b0, item_q.h};

	assign horiz = pend_s1 && first_s1 && (x_end == {2'b00, item_q.x})
		&& (rd_data.y == item_q.y) && (rd_data.h == item_q.h)
		&& (grown_w <= 14'(rrc_pkg::SIZE_MAX_OUT));
	assign vert  = pend_s1 && (y_end == {2'b00, item_q.y})
		&& (rd_data.x == item_q.x) && (rd_data.w == item_q.w)
		&& (grown_h <= 14'(rrc_pkg::SIZE_MAX_OUT));
	assign merge = horiz || vert;
	assign miss  = pend_s1 && !merge && (addr_s1 == '0);

	assign out_free  = !out_valid_q || !out_stall;
	assign emit_last = (addr_s1 == newest);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rrc_pkg::ST_IDLE: begin
				if (accept) begin
					if (in_flush == rrc_pkg::OP_FLUSH) begin
						state_d = empty ? rrc_pkg::ST_IDLE : rrc_pkg::ST_EMIT;
					end else begin
						state_d = empty ? rrc_pkg::ST_APPEND : rrc_pkg::ST_SEARCH;
					end
				end
			end
			rrc_pkg::ST_SEARCH: begin
				if (merge) begin
					state_d = rrc_pkg::ST_IDLE;
				end else if (miss) begin
					state_d = full ? rrc_pkg::ST_EMIT : rrc_pkg::ST_APPEND;
				end
			end
			rrc_pkg::ST_EMIT: begin
				if (pend_s1 && out_free && emit_last) begin
					state_d = (flush_q == rrc_pkg::OP_FLUSH) ? rrc_pkg::ST_IDLE
						: rrc_pkg::ST_APPEND;
				end
			end
			rrc_pkg::ST_APPEND: begin
				state_d = rrc_pkg::ST_IDLE;
			end
			default: begin
				state_d = rrc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		mem_ctl     = '0;
		rd_addr     = ptr_q;
		wr_addr     = addr_s1;
		wr_data     = rd_data;
		count_d     = count_q;
		ptr_d       = ptr_q;
		issued_d    = issued_q;
		flush_d     = flush_q;
		item_d      = item_q;
		pend_d      = pend_s1;
		addr_d      = addr_s1;
		first_d     = first_s1;
		out_valid_d = out_valid_q && out_stall;
		out_rect_d  = out_rect_q;
		out_last_d  = out_last_q;
		unique case (state_q)
			rrc_pkg::ST_IDLE: begin
				pend_d = 1'b0;
				if (accept) begin
					item_d   = in_item;
					flush_d  = in_flush;
					issued_d = 1'b0;
					ptr_d    = (in_flush == rrc_pkg::OP_FLUSH) ? '0 : newest;
				end
			end
			rrc_pkg::ST_SEARCH: begin
				// newest to oldest, one read a cycle
				mem_ctl.rd_en = !issued_q;
				pend_d        = !issued_q;
				addr_d        = ptr_q;
				first_d       = (ptr_q == newest);
				if (!issued_q) begin
					if (ptr_q == '0) begin
						issued_d = 1'b1;
					end else begin
						ptr_d = ptr_q - AW'(1);
					end
				end
				if (horiz) begin
					mem_ctl.wr_en = 1'b1;
					wr_data.w     = grown_w[12:0];
				end else if (vert) begin
					mem_ctl.wr_en = 1'b1;
					wr_data.h     = grown_h[12:0];
				end
				if (merge || miss) begin
					pend_d = 1'b0;
					ptr_d  = '0;
				end
			end
			rrc_pkg::ST_EMIT: begin
				if (pend_s1) begin
					if (out_free) begin
						out_valid_d = 1'b1;
						out_rect_d  = rd_data;
						out_last_d  = emit_last;
						if (emit_last) begin
							pend_d  = 1'b0;
							count_d = '0;
						end else begin
							mem_ctl.rd_en = 1'b1;
							addr_d        = ptr_q;
							ptr_d         = ptr_q + AW'(1);
						end
					end
				end else begin
					mem_ctl.rd_en = 1'b1;
					pend_d        = 1'b1;
					addr_d        = ptr_q;
					ptr_d         = ptr_q + AW'(1);
				end
			end
			rrc_pkg::ST_APPEND: begin
				mem_ctl.wr_en = 1'b1;
				wr_addr       = count_q[AW-1:0];
				wr_data       = item_q;
				count_d       = count_q + CW'(1);
			end
			default: begin
				pend_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rrc_pkg::ST_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			issued_q    <= 1'b0;
			flush_q     <= 1'b0;
			pend_s1     <= 1'b0;
			addr_s1     <= '0;
			first_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			ptr_q       <= ptr_d;
			issued_q    <= issued_d;
			flush_q     <= flush_d;
			pend_s1     <= pend_d;
			addr_s1     <= addr_d;
			first_s1    <= first_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		item_q     <= item_d;
		out_rect_q <= out_rect_d;
		out_last_q <= out_last_d;
	end

	assign out_valid = out_valid_q;
	assign out_rect  = out_rect_q;
	assign out_last  = out_last_q;

endmodule

@@ sv/rectangle_run_coalescer.sv @@
// Top level of the rectangle run coalescer: scale registers, input scaling, store and sequencer.
//
//  channel | handshake             | beat
//  --------+-----------------------+------------------------------------------------
//  in      | in_valid / in_stall   | operation, run_x, run_y, run_width, run_height
//  out     | out_valid / out_stall | rect_x, rect_y, rect_width, rect_height, last_of_batch
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// An add is accepted, then the held entries are read newest to oldest, one a cycle, through the
// registered read port; a merge ends the search, else the item is appended to the batch.
// Flush, or an add into a full batch, first emits every held rectangle, holding while out_stall is high.
// One item is in work at a time; in_stall is high until it is done.
// Reset empties the batch and sets both scales to 1; no clearing pass.
// A stalled output only holds emission; a finished result waits in the output register.
module rectangle_run_coalescer #(
	parameter int BATCH_DEPTH = rrc_pkg::BATCH_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [8:0]  run_x,
	input  logic [8:0]  run_y,
	input  logic [9:0]  run_width,
	input  logic [9:0]  run_height,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] rect_x,
	output logic [11:0] rect_y,
	output logic [12:0] rect_width,
	output logic [12:0] rect_height,
	output logic        last_of_batch,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data
);

	localparam int AW = $clog2(BATCH_DEPTH);

	logic [3:0]        sx_q, sy_q;
	logic [12:0]       x_prod, y_prod;
	logic [13:0]       w_prod, h_prod;
	rrc_pkg::rect_t    in_item;
	rrc_pkg::rect_t    out_rect;
	rrc_pkg::rect_t    wr_data, rd_data;
	rrc_pkg::mem_ctl_t mem_ctl;
	logic [AW-1:0]     rd_addr, wr_addr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= 4'd1;
			sy_q <= 4'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rrc_pkg::CFG_SCALE_X: sx_q <= rrc_pkg::scale_sat(cfg_data);
				rrc_pkg::CFG_SCALE_Y: sy_q <= rrc_pkg::scale_sat(cfg_data);
				default: begin
				end
			endcase
		end
	end

	assign x_prod = {4'd0, run_x} * {9'd0, sx_q};
	assign y_prod = {4'd0, run_y} * {9'd0, sy_q};
	assign w_prod = {4'd0, rrc_pkg::run_sat(run_width)} * {10'd0, sx_q};
	assign h_prod = {4'd0, rrc_pkg::run_sat(run_height)} * {10'd0, sy_q};

	assign in_item.x = x_prod[11:0];
	assign in_item.y = y_prod[11:0];
	assign in_item.w = w_prod[12:0];
	assign in_item.h = h_prod[12:0];

	rrc_store #(
		.DEPTH(BATCH_DEPTH)
	) u_store (
		.clk    (clk),
		.mem_ctl(mem_ctl),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_data(rd_data)
	);

	rrc_ctrl #(
		.DEPTH(BATCH_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_flush (operation),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_rect (out_rect),
		.out_last (last_of_batch),
		.mem_ctl  (mem_ctl),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_data  (rd_data)
	);

	assign rect_x      = out_rect.x;
	assign rect_y      = out_rect.y;
	assign rect_width  = out_rect.w;
	assign rect_height = out_rect.h;

endmodule

@@ sv/rrc_checker.sv @@
// Port-level checks for the rectangle run coalescer, bound to the top level.
module rrc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        operation,
	input logic        out_valid,
	input logic        out_stall,
	input logic [11:0] rect_x,
	input logic [11:0] rect_y,
	input logic [12:0] rect_width,
	input logic [12:0] rect_height,
	input logic        last_of_batch
);

	// a stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rect_x) && $stable(rect_y)
			&& $stable(rect_width) && $stable(rect_height) && $stable(last_of_batch))
		else $error("stalled output beat changed");

	// an accepted add is always followed by in_stall
	a_add_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (operation == rrc_pkg::OP_ADD) |=> in_stall)
		else $error("add accepted without follow-up cycle");

	// emitted sizes stay within output range
	a_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (rect_width != 13'd0) && (rect_height != 13'd0)
			&& (rect_width <= 13'(rrc_pkg::SIZE_MAX_OUT))
			&& (rect_height <= 13'(rrc_pkg::SIZE_MAX_OUT)))
		else $error("emitted rectangle size out of range");

endmodule

bind rectangle_run_coalescer rrc_checker u_rrc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.operation    (operation),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.rect_x       (rect_x),
	.rect_y       (rect_y),
	.rect_width   (rect_width),
	.rect_height  (rect_height),
	.last_of_batch(last_of_batch)
);
